// ===== design/xpfa_pkg.sv =====
// xpfa_pkg: types, codes and constants shared by the XY point frame arranger.
// No dependencies; every other design file imports it.

package xpfa_pkg;

    // Fixed field widths
    localparam int COORD_W = 16;
    localparam int FRAME_W = 16;
    localparam int POINT_W = 2 * COORD_W;

    // Defaults handed to the top level
    localparam int DEF_POINT_DEPTH = 1024;

    // Front queue between accept and execute
    localparam int QUEUE_DEPTH = 2;

    // APB register map
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_FRAME_SAMPLES = 1'b0;
    localparam logic REG_ARRANGE_MODE  = 1'b1;

    localparam logic [FRAME_W-1:0] FRAME_SAMPLES_RST = FRAME_W'(800);
    localparam logic               ARRANGE_MODE_RST  = 1'b0;

    // Arrange modes
    localparam logic MODE_STRETCH = 1'b0;
    localparam logic MODE_CYCLE   = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_EMIT  = 2'd2
    } op_t;

    typedef struct packed {
        op_t                       operation;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } in_beat_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] sample_x;
        logic signed [COORD_W-1:0] sample_y;
        logic                      frame_end;
    } out_beat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_SEARCH,
        ST_EMIT
    } back_state_t;

endpackage

// ===== design/xpfa_front.sv =====
// xpfa_front: input accept, operation filter and a short command queue.
// Depends on xpfa_pkg.

module xpfa_front
    import xpfa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_beat_t in_data,
    output logic     q_valid,
    output in_beat_t q_data,
    input  logic     q_pop
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    in_beat_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               is_cmd;
    logic               push;
    logic               pop;

    // unused operation code is swallowed here, never queued
    assign is_cmd   = in_data.operation inside {OP_LOAD, OP_CLEAR, OP_EMIT};
    assign in_stall = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall && is_cmd;
    assign q_valid  = (fill_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_data   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== design/xpfa_back.sv =====
// xpfa_back: point store, stretch/cycle sequencer and output register.
// Depends on xpfa_pkg; fed by xpfa_front.

module xpfa_back
    import xpfa_pkg::*;
#(
    parameter int POINT_DEPTH = DEF_POINT_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  in_beat_t           q_data,
    output logic               q_pop,
    input  logic [FRAME_W-1:0] frame_samples,
    input  logic               arrange_mode,
    output logic               out_valid,
    input  logic               out_stall,
    output out_beat_t          out_data
);

    localparam int CNT_W  = $clog2(POINT_DEPTH + 1);
    localparam int IDX_W  = $clog2(POINT_DEPTH);
    localparam int PROD_W = FRAME_W + 1 + CNT_W;

    back_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   ri_reg, ri_next;
    logic [FRAME_W-1:0] si_reg, si_next;
    logic [PROD_W-1:0]  ss_reg, ss_next;
    logic [PROD_W-1:0]  ps_reg, ps_next;
    logic               zero_reg, zero_next;
    logic               out_valid_reg, out_valid_next;
    out_beat_t          out_data_reg, out_data_next;

    logic [POINT_W-1:0] mem [POINT_DEPTH];
    logic [POINT_W-1:0] rd_data_reg;
    logic               mem_we;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_ra;

    logic [FRAME_W-1:0] len;
    logic [FRAME_W:0]   si_inc;
    logic [CNT_W-1:0]   ri_inc;
    logic [IDX_W-1:0]   ri_clamp;
    logic [CNT_W-1:0]   clamp_inc;
    logic [IDX_W-1:0]   ri_adv;
    logic               last;
    logic               slot_free;
    logic               step;

    assign len       = (frame_samples == '0) ? FRAME_W'(1) : frame_samples;
    assign si_inc    = {1'b0, si_reg} + (FRAME_W + 1)'(1);
    assign last      = (si_inc >= {1'b0, len});
    assign ri_inc    = CNT_W'(ri_reg) + CNT_W'(1);
    assign ri_clamp  = (CNT_W'(ri_reg) < count_reg) ? ri_reg
                     : (arrange_mode == MODE_CYCLE) ? '0
                     : IDX_W'(count_reg - CNT_W'(1));
    assign clamp_inc = CNT_W'(ri_clamp) + CNT_W'(1);
    assign ri_adv    = (clamp_inc >= count_reg) ? '0 : IDX_W'(clamp_inc);
    assign slot_free = !out_valid_reg || !out_stall;
    // next point still lies before this sample's boundary
    assign step      = (ps_reg < ss_reg) && (ri_inc < count_reg);

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && q_data.operation == OP_EMIT)
                begin
                    if (count_reg == '0 || arrange_mode == MODE_CYCLE)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_SCALE;
                    end
                end
            end
            ST_SCALE:  state_next = ST_SEARCH;
            ST_SEARCH:
            begin
                if (!step)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next     = count_reg;
        ri_next        = ri_reg;
        si_next        = si_reg;
        ss_next        = ss_reg;
        ps_next        = ps_reg;
        zero_next      = zero_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_stall ? out_valid_reg : 1'b0;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_ra         = ri_reg;
        case (state_reg)
            ST_IDLE:
            begin
                q_pop = q_valid;
                if (q_valid)
                begin
                    case (q_data.operation)
                        OP_LOAD:
                        begin
                            if (count_reg < CNT_W'(POINT_DEPTH))
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            ri_next    = '0;
                        end
                        OP_EMIT:
                        begin
                            zero_next = (count_reg == '0);
                            if (count_reg != '0)
                            begin
                                ri_next = ri_clamp;
                                if (arrange_mode == MODE_CYCLE)
                                begin
                                    mem_re  = 1'b1;
                                    mem_ra  = ri_clamp;
                                    ri_next = ri_adv;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCALE:
            begin
                ss_next = PROD_W'(si_inc) * PROD_W'(count_reg);
                ps_next = PROD_W'(ri_inc) * PROD_W'(len);
            end
            ST_SEARCH:
            begin
                if (step)
                begin
                    ri_next = IDX_W'(ri_inc);
                    ps_next = ps_reg + PROD_W'(len);
                end
                else
                begin
                    mem_re = 1'b1;
                    mem_ra = ri_reg;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.sample_x  = zero_reg ? '0 : rd_data_reg[COORD_W-1:0];
                    out_data_next.sample_y  = zero_reg ? '0
                                                       : rd_data_reg[POINT_W-1:COORD_W];
                    out_data_next.frame_end = last;
                    if (last)
                    begin
                        si_next = '0;
                        if (arrange_mode == MODE_STRETCH)
                        begin
                            count_next = '0;
                            ri_next    = '0;
                        end
                    end
                    else
                    begin
                        si_next = FRAME_W'(si_inc);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ri_reg        <= '0;
            si_reg        <= '0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ri_reg        <= ri_next;
            si_reg        <= si_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ss_reg       <= ss_next;
        ps_reg       <= ps_next;
        out_data_reg <= out_data_next;
    end

    // point store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[IDX_W-1:0]] <= {q_data.point_y, q_data.point_x};
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

endmodule

// ===== design/xy_point_frame_arranger.sv =====
// xy_point_frame_arranger: top level with APB registers, front queue and back sequencer.
// Depends on xpfa_pkg, xpfa_front and xpfa_back.
//
//  Channel | Direction | Handshake                 | Beat
//  --------+-----------+---------------------------+-----------------------------------
//  in      | in        | in_valid / in_stall       | in_beat_t: operation, point_x, y
//  out     | out       | out_valid / out_stall     | out_beat_t: sample_x, sample_y, frame_end
//  apb     | in        | psel, penable / pready=1  | frame_samples (0x0), arrange_mode (0x4)
//
// Steps: an input beat enters the two-entry queue; unused codes are dropped there.
//   The back end takes a load or clear straight from idle. An emit from an empty
//   store goes straight to the output register, one in cycle mode reads the store
//   and then the output register, and a stretch-mode emit runs scale, search, store
//   read and output, the scaled-index search loop skipping one point per cycle.
// Reset clears the queue, point count, read and sample positions and the registers
//   to 800 samples, stretch mode. The point store is not cleared; it is read only
//   below the point count.
// A stalled output holds its beat; the queue keeps taking input until it is full.

module xy_point_frame_arranger
    import xpfa_pkg::*;
#(
    parameter int POINT_DEPTH = DEF_POINT_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_beat_t              in_data,

    output logic                  out_valid,
    input  logic                  out_stall,
    output out_beat_t             out_data,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [FRAME_W-1:0] frame_samples_reg, frame_samples_next;
    logic               arrange_mode_reg, arrange_mode_next;
    logic               cfg_write;

    logic               q_valid;
    in_beat_t           q_data;
    logic               q_pop;

    // APB: no wait states, register index from address bit 2
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        frame_samples_next = frame_samples_reg;
        arrange_mode_next  = arrange_mode_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                REG_FRAME_SAMPLES: frame_samples_next = pwdata[FRAME_W-1:0];
                REG_ARRANGE_MODE:  arrange_mode_next  = pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_FRAME_SAMPLES: prdata = APB_DATA_W'(frame_samples_reg);
            REG_ARRANGE_MODE:  prdata = APB_DATA_W'(arrange_mode_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_samples_reg <= FRAME_SAMPLES_RST;
            arrange_mode_reg  <= ARRANGE_MODE_RST;
        end
        else
        begin
            frame_samples_reg <= frame_samples_next;
            arrange_mode_reg  <= arrange_mode_next;
        end
    end

    // front: accept and filter beats into the command queue
    xpfa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop)
    );

    // back: point store, stretch search and output register
    xpfa_back #(
        .POINT_DEPTH (POINT_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .frame_samples (frame_samples_reg),
        .arrange_mode  (arrange_mode_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data)
    );

endmodule

// ===== design/xpfa_checker.sv =====
// xpfa_props: port-level assertions for the XY point frame arranger, bound to the top.
// Depends on xpfa_pkg and xy_point_frame_arranger.

module xpfa_props
    import xpfa_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_stall,
    input out_beat_t             out_data,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata
);

    // held output beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // nothing leaves straight out of reset
    a_rst_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid just after reset");

    // frame length reads back as written
    a_frame_rb: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && paddr[2] == REG_FRAME_SAMPLES)
        ##1 (psel && !pwrite && paddr[2] == REG_FRAME_SAMPLES)
        |-> prdata[FRAME_W-1:0] == $past(pwdata[FRAME_W-1:0]))
        else $error("frame_samples read-back mismatch");

    // mode register reads back as written
    a_mode_rb: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && paddr[2] == REG_ARRANGE_MODE)
        ##1 (psel && !pwrite && paddr[2] == REG_ARRANGE_MODE)
        |-> prdata[0] == $past(pwdata[0]))
        else $error("arrange_mode read-back mismatch");

endmodule

bind xy_point_frame_arranger xpfa_props u_xpfa_props (.*);

// ===== tb/xpfa_checker.sv =====
// xpfa_checker: watches the in, out and APB ports of the XY point frame arranger,
// predicts every sample beat and compares it field by field. Depends on xpfa_pkg.

module xpfa_checker
    import xpfa_pkg::*;
#(
    parameter int POINT_DEPTH = DEF_POINT_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  in_beat_t              in_data,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  out_beat_t             out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int unsigned           fail_count,
    output int unsigned           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // stored as {y, x}
    logic [POINT_W-1:0] point_mem [POINT_DEPTH];
    int unsigned        pt_count;
    int unsigned        rd_pos;
    int unsigned        smp_pos;
    logic [FRAME_W-1:0] cfg_frame;
    logic               cfg_mode;
    out_beat_t          expected_samples [$];
    int unsigned        mismatch_total = 0;

    assign fail_count = mismatch_total;

    task automatic report_mismatch(input string what);
        $display("checker: %s (t=%0t)", what, $time);
        mismatch_total++;
    endtask

    // next sample of the frame; advances read and frame positions, and at a stretch frame end empties the store
    function automatic out_beat_t emit_sample();
        longint unsigned    span;
        longint unsigned    need;
        longint unsigned    reach;
        logic [POINT_W-1:0] pt;
        out_beat_t          beat;
        span = (cfg_frame == '0) ? 1 : 64'(cfg_frame);
        pt   = '0;
        if (pt_count != 0)
        begin
            if (rd_pos >= pt_count)
                rd_pos = (cfg_mode == MODE_CYCLE) ? 0 : pt_count - 1;
            if (cfg_mode == MODE_STRETCH)
            begin
                // exact nearest-neighbour: smallest j with (k+1)*count <= (j+1)*frame
                need  = (64'(smp_pos) + 1) * pt_count;
                reach = (64'(rd_pos) + 1) * span;
                while (reach < need && rd_pos + 1 < pt_count)
                begin
                    rd_pos++;
                    reach += span;
                end
                pt = point_mem[rd_pos];
            end
            else
            begin
                pt     = point_mem[rd_pos];
                rd_pos = (rd_pos + 1 >= pt_count) ? 0 : rd_pos + 1;
            end
        end
        beat.sample_x  = pt[COORD_W-1:0];
        beat.sample_y  = pt[POINT_W-1:COORD_W];
        beat.frame_end = (64'(smp_pos) + 1 >= span);
        if (beat.frame_end)
        begin
            smp_pos = 0;
            if (cfg_mode == MODE_STRETCH)
            begin
                pt_count = 0;
                rd_pos   = 0;
            end
        end
        else
            smp_pos++;
        return beat;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t want;
        if (!rst_n)
        begin
            pt_count  = 0;
            rd_pos    = 0;
            smp_pos   = 0;
            cfg_frame = FRAME_SAMPLES_RST;
            cfg_mode  = ARRANGE_MODE_RST;
            expected_samples.delete();
            pending <= 0;
        end
        else
        begin
            // results first: a beat leaving now belongs to an older request
            if (out_valid && !out_stall)
            begin
                if (expected_samples.size() == 0)
                    report_mismatch("sample beat with nothing expected");
                else
                begin
                    want = expected_samples.pop_front();
                    if (out_data.sample_x !== want.sample_x)
                        report_mismatch($sformatf("sample_x %0d, predicted %0d",
                                                  out_data.sample_x, want.sample_x));
                    if (out_data.sample_y !== want.sample_y)
                        report_mismatch($sformatf("sample_y %0d, predicted %0d",
                                                  out_data.sample_y, want.sample_y));
                    if (out_data.frame_end !== want.frame_end)
                        report_mismatch($sformatf("frame_end %0b, predicted %0b",
                                                  out_data.frame_end, want.frame_end));
                end
            end

            if (in_valid && !in_stall)
            begin
                case (in_data.operation)
                    OP_LOAD:
                    begin
                        if (pt_count < POINT_DEPTH)
                        begin
                            point_mem[pt_count] = {in_data.point_y, in_data.point_x};
                            pt_count++;
                        end
                    end
                    OP_CLEAR:
                    begin
                        pt_count = 0;
                        rd_pos   = 0;
                    end
                    OP_EMIT:
                        expected_samples.push_back(emit_sample());
                    default:
                        ;
                endcase
            end

            if (psel && penable && pwrite && pready)
            begin
                if (paddr[APB_ADDR_W-1:2] == REG_FRAME_SAMPLES)
                    cfg_frame = pwdata[FRAME_W-1:0];
                else if (paddr[APB_ADDR_W-1:2] == REG_ARRANGE_MODE)
                    cfg_mode = pwdata[0];
            end

            pending <= expected_samples.size();
        end
    end

endmodule

// ===== tb/xy_point_frame_arranger_tb.sv =====
// xy_point_frame_arranger_tb: drives request beats, sample stalls and APB writes,
// and gives the verdict. Depends on xpfa_pkg, xpfa_checker and the design top.

module xy_point_frame_arranger_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import xpfa_pkg::*;

    // the one code op_t leaves unnamed; the block must swallow it
    localparam op_t OP_UNUSED     = op_t'(2'd3);
    localparam int  RANDOM_BEATS  = 370;
    // quiet cycles after the last sample before touching registers,
    // so that loads and clears left in the queue are taken first
    localparam int  SETTLE_CYCLES = 24;
    // a stretch emit over a full store could skip about a thousand points,
    // one per cycle, on top of the longest gap and stall
    localparam int  WATCHDOG_LIMIT = 4000;

    logic                  clk     = 1'b0;
    logic                  rst_n   = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_beat_t              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b1;
    out_beat_t             out_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int unsigned fail_count;
    int unsigned pending;

    // upper bound of the per-beat wait on both sides; 0 gives back-to-back stretches
    int          idle_max    = 11;
    // frame length as last written, used only to shape whole-frame sequences
    int          cur_frame   = int'(FRAME_SAMPLES_RST);
    int unsigned beats_sent  = 0;
    int unsigned quiet_cycles = 0;

    xy_point_frame_arranger dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    xpfa_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Watchdog: any beat on either channel or an APB access counts as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Sample sink: before each beat it holds stall for a random count of cycles,
    // then drops it and waits for the beat to go through.
    initial
    begin : sample_sink
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, idle_max);
            if (gap != 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    // Extremes turn up often; otherwise any 16-bit pattern.
    function automatic logic [COORD_W-1:0] random_coord();
        case ($urandom_range(0, 7))
            0:       return {1'b1, {(COORD_W-1){1'b0}}};
            1:       return {1'b0, {(COORD_W-1){1'b1}}};
            default: return COORD_W'($urandom);
        endcase
    endfunction

    // One request beat: optional gap with valid low, then hold until accepted.
    // Valid stays high on return so the next beat can follow without a bubble.
    task automatic send_beat(input op_t op, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y);
        int       gap;
        in_beat_t beat;
        gap            = $urandom_range(0, idle_max);
        beat.operation = op;
        beat.point_x   = x;
        beat.point_y   = y;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do
            @(posedge clk);
        while (in_stall);
        if (op != OP_UNUSED)
            beats_sent++;
    endtask

    task automatic send_random(input op_t op);
        send_beat(op, random_coord(), random_coord());
    endtask

    // Drain: stop requests, wait for the next edge so the count includes the last beat,
    // wait for every predicted sample, then let the queue empty of loads and
    // clears that produce nothing.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // edge that ends the access. Leading edge keeps back-to-back writes apart.
    task automatic apb_write(input logic reg_idx, input logic [APB_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(reg_idx) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_idx == REG_FRAME_SAMPLES)
            cur_frame = int'(value[FRAME_W-1:0]);
    endtask

    initial
    begin : stimulus
        int unsigned random_stop;
        int          n_loads;
        int          n_emits;
        int          pick;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed ----
        // Reset config (800 samples, stretch): emit from an empty store gives the
        // origin while the frame position moves on; unused code and a clear on
        // an empty store change nothing visible.
        send_random(OP_EMIT);
        send_random(OP_UNUSED);
        send_random(OP_CLEAR);

        // Zero frame length acts as one; lowered below the current position,
        // so the very next sample closes the frame and empties the store.
        settle();
        apb_write(REG_FRAME_SAMPLES, '0);
        send_beat(OP_LOAD, 16'h8000, 16'h7FFF);
        send_beat(OP_LOAD, 16'h7FFF, 16'h8000);
        send_random(OP_EMIT);
        send_random(OP_EMIT);

        // Five-sample stretch with a point loaded mid-frame.
        settle();
        apb_write(REG_FRAME_SAMPLES, 5);
        send_beat(OP_LOAD, 16'h0000, 16'hFFFF);
        send_beat(OP_LOAD, 16'hFFFF, 16'h0000);
        send_random(OP_EMIT);
        send_beat(OP_LOAD, 16'h5555, 16'hAAAA);
        repeat (3) send_random(OP_EMIT);

        // Mode change mid-frame to cycle: points wrap, store survives frame
        // end, then a clear leaves an empty store.
        settle();
        apb_write(REG_ARRANGE_MODE, APB_DATA_W'(MODE_CYCLE));
        apb_write(REG_FRAME_SAMPLES, 3);
        repeat (2) send_random(OP_LOAD);
        repeat (4) send_random(OP_EMIT);
        send_random(OP_CLEAR);
        send_random(OP_EMIT);

        // Longest frame, then cut short mid-frame.
        settle();
        apb_write(REG_ARRANGE_MODE, APB_DATA_W'(MODE_STRETCH));
        apb_write(REG_FRAME_SAMPLES, APB_DATA_W'({FRAME_W{1'b1}}));
        repeat (3) send_random(OP_LOAD);
        repeat (4) send_random(OP_EMIT);
        settle();
        apb_write(REG_FRAME_SAMPLES, 2);
        send_random(OP_EMIT);

        // ---- random ----
        // Mostly whole-frame sequences (loads, then a frame of emits, capped at 24) under a
        // fresh config; the rest mixed noise with unused codes and clears.
        random_stop = beats_sent + RANDOM_BEATS;
        while (beats_sent < random_stop)
        begin
            settle();
            idle_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
            if ($urandom_range(0, 3) != 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    apb_write(REG_FRAME_SAMPLES, '0);
                else if (pick == 1)
                    apb_write(REG_FRAME_SAMPLES, APB_DATA_W'({FRAME_W{1'b1}}));
                else
                    apb_write(REG_FRAME_SAMPLES, $urandom_range(1, 12));
            end
            if ($urandom_range(0, 1) != 0)
                apb_write(REG_ARRANGE_MODE, APB_DATA_W'($urandom_range(0, 1)));

            if ($urandom_range(0, 3) != 0)
            begin
                // loads may outnumber the samples, so the stretch search skips
                n_loads = $urandom_range(0, 16);
                n_emits = (cur_frame == 0) ? 1 : ((cur_frame > 24) ? 24 : cur_frame);
                repeat (n_loads) send_random(OP_LOAD);
                repeat (n_emits) send_random(OP_EMIT);
            end
            else
            begin
                repeat ($urandom_range(4, 12))
                    send_random(op_t'($urandom_range(0, 3)));
            end
        end

        // ---- end ----
        settle();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== xy_point_frame_arranger.f =====
design/xpfa_pkg.sv
design/xpfa_front.sv
design/xpfa_back.sv
design/xy_point_frame_arranger.sv
design/xpfa_checker.sv
tb/xpfa_checker.sv
tb/xy_point_frame_arranger_tb.sv
